// ===== hdl/bale_pkg.sv =====
// Shared types, codes and constants of the bounded array list engine.
`timescale 1ns / 1ps
`default_nettype none
package bale_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int MAX_RUN       = 64;

  localparam int OP_W    = 4;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 7;
  localparam int DATA_W  = 32;
  localparam int WHERE_W = 6;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 4'd0,
    OP_REMOVE = 4'd1,
    OP_INSERT = 4'd2,
    OP_ERASE  = 4'd3,
    OP_READ   = 4'd4,
    OP_WRITE  = 4'd5,
    OP_REV    = 4'd6,
    OP_SORT   = 4'd7,
    OP_FIND   = 4'd8,
    OP_CLEAR  = 4'd9,
    OP_RANGE  = 4'd10
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_ERR  = 2'd1,
    STAT_NONE = 2'd2
  } stat_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_RDOUT,
    S_SHUP,
    S_SHUP_WR,
    S_ERCHK,
    S_ERSH,
    S_ERSH_WR,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_REV_D,
    S_SO_I,
    S_SO_LD,
    S_SO_J,
    S_SO_CMP,
    S_FI,
    S_FI_CMP,
    S_RG,
    S_RG_OUT,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/bale_if.sv =====
// Request and result channel interfaces of the list engine.
`timescale 1ns / 1ps
`default_nettype none
interface bale_in_if;
  logic                                valid;
  logic                                ready;
  logic [bale_pkg::OP_W-1:0]           operation;
  logic [bale_pkg::POS_W-1:0]          position;
  logic [bale_pkg::CNT_W-1:0]          range_count;
  logic signed [bale_pkg::DATA_W-1:0]  operand;
  modport source (output valid, operation, position, range_count, operand, input ready);
  modport sink   (input valid, operation, position, range_count, operand, output ready);
endinterface

interface bale_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bale_pkg::DATA_W-1:0]  word;
  logic [bale_pkg::WHERE_W-1:0]        where;
  logic [bale_pkg::STAT_W-1:0]         status;
  logic [bale_pkg::LEN_W-1:0]          current_length;
  logic                                last;
  modport source (output valid, word, where, status, current_length, last, input ready);
  modport sink   (input valid, word, where, status, current_length, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/bounded_array_list_engine_core.sv =====
// Top level: sequencer over the word store and its compare signals.
// Append, write, clear and errors answer from dispatch; read, remove and erase first read the store.
// Insert and erase shift one word per read and write pair; reverse reads both ends, then writes both.
// Sort compares every pair i<j as signed words, ascending; find scans up to MAX_RUN hits; range reads each word.
// One request at a time: a new request is taken only when the sequencer is back in idle.
// Reset clears length and control; store contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module bounded_array_list_engine_core #(
  parameter int CAPACITY  = bale_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = bale_pkg::WORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bale_in_if.sink    in_i,
  bale_out_if.source out_o
);
  import bale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = ((CW > 7) ? CW : 7) + 1;

  state_e state_q, state_d, ret_q, ret_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [EW-1:0]        pos_q, pos_d, cnt_q, cnt_d;
  logic [WORD_BITS-1:0] val_q, val_d, ta_q, ta_d, pw_q, pw_d;
  logic [CW-1:0]        n_q, n_d;
  logic [EW-1:0]        i_q, i_d, j_q, j_d, k_q, k_d, ph_q, ph_d;
  logic                 pend_q, pend_d;
  logic [DATA_W-1:0]    ow_q, ow_d;
  logic [WHERE_W-1:0]   oh_q, oh_d;
  logic [STAT_W-1:0]    os_q, os_d;
  logic                 ol_q, ol_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, rdata;

  bale_mem #(.DEPTH(CAPACITY), .WIDTH(WORD_BITS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  logic [EW-1:0] ne;
  logic c_app, c_pop, c_ins, c_pos, c_rng, c_shup, c_ersh, c_rev, c_iltn, c_jltn;
  logic c_eq, c_gt, c_fi, c_rlast, c_acc;

  assign ne      = EW'(n_q);
  assign c_app   = n_q < CW'(CAPACITY);
  assign c_pop   = n_q != '0;
  assign c_ins   = c_app && (pos_q <= ne);
  assign c_pos   = pos_q < ne;
  assign c_rng   = (cnt_q != '0) && (cnt_q <= EW'(MAX_RUN)) && ((pos_q + cnt_q) <= ne);
  assign c_shup  = i_q > pos_q;
  assign c_ersh  = (i_q + 1'b1) < ne;
  assign c_rev   = i_q < (ne >> 1);
  assign c_iltn  = i_q < ne;
  assign c_jltn  = j_q < ne;
  assign c_eq    = rdata == val_q;
  assign c_gt    = $signed(ta_q) > $signed(rdata);
  assign c_fi    = c_iltn && (k_q < EW'(MAX_RUN));
  assign c_rlast = (i_q + 1'b1) == j_q;
  assign c_acc   = in_i.valid && in_i.ready;

  function automatic logic [DATA_W-1:0] from_word(input logic [WORD_BITS-1:0] w);
    return DATA_W'($signed(w));
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (c_acc) state_d = S_DISP;
      S_DISP: begin
        case (op_q)
          OP_REMOVE: state_d = c_pop ? S_RDOUT : S_OUT;
          OP_READ:   state_d = c_pos ? S_RDOUT : S_OUT;
          OP_INSERT: state_d = c_ins ? S_SHUP : S_OUT;
          OP_ERASE:  state_d = c_pos ? S_ERCHK : S_OUT;
          OP_REV:    state_d = S_REV_A;
          OP_SORT:   state_d = S_SO_I;
          OP_FIND:   state_d = S_FI;
          OP_RANGE:  state_d = c_rng ? S_RG : S_OUT;
          default:   state_d = S_OUT;
        endcase
      end
      S_RDOUT:   state_d = S_OUT;
      S_SHUP:    state_d = c_shup ? S_SHUP_WR : S_OUT;
      S_SHUP_WR: state_d = S_SHUP;
      S_ERCHK:   state_d = c_eq ? S_ERSH : S_OUT;
      S_ERSH:    state_d = c_ersh ? S_ERSH_WR : S_OUT;
      S_ERSH_WR: state_d = S_ERSH;
      S_REV_A:   state_d = c_rev ? S_REV_B : S_OUT;
      S_REV_B:   state_d = S_REV_C;
      S_REV_C:   state_d = S_REV_D;
      S_REV_D:   state_d = S_REV_A;
      S_SO_I:    state_d = c_iltn ? S_SO_LD : S_OUT;
      S_SO_LD:   state_d = S_SO_J;
      S_SO_J:    state_d = c_jltn ? S_SO_CMP : S_SO_I;
      S_SO_CMP:  state_d = S_SO_J;
      S_FI:      state_d = c_fi ? S_FI_CMP : S_OUT;
      S_FI_CMP:  state_d = (c_eq && pend_q) ? S_OUT : S_FI;
      S_RG:      state_d = S_RG_OUT;
      S_RG_OUT:  state_d = S_OUT;
      S_OUT:     if (out_o.ready) state_d = ret_q;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d = op_q; pos_d = pos_q; cnt_d = cnt_q; val_d = val_q;
    n_d = n_q; i_d = i_q; j_d = j_q; k_d = k_q; ta_d = ta_q;
    pend_d = pend_q; pw_d = pw_q; ph_d = ph_q; ret_d = ret_q;
    ow_d = ow_q; oh_d = oh_q; os_d = os_q; ol_d = ol_q;
    mem_we = 1'b0; mem_waddr = i_q[AW-1:0]; mem_wdata = rdata; mem_raddr = i_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        op_d  = in_i.operation;
        pos_d = EW'(in_i.position);
        cnt_d = EW'(in_i.range_count);
        val_d = WORD_BITS'(in_i.operand);
        ret_d = S_IDLE;
        ow_d = '0; oh_d = '0; os_d = STAT_ERR; ol_d = 1'b1;
      end
      S_DISP: begin
        case (op_q)
          OP_APPEND: if (c_app) begin
            mem_we = 1'b1; mem_waddr = ne[AW-1:0]; mem_wdata = val_q;
            n_d = n_q + 1'b1; oh_d = WHERE_W'(n_q); os_d = STAT_OK;
          end
          OP_REMOVE: begin
            i_d = ne - 1'b1; mem_raddr = i_d[AW-1:0];
          end
          OP_READ: begin
            i_d = pos_q; mem_raddr = pos_q[AW-1:0];
          end
          OP_INSERT: i_d = ne;
          OP_ERASE: mem_raddr = pos_q[AW-1:0];
          OP_WRITE: if (c_pos) begin
            mem_we = 1'b1; mem_waddr = pos_q[AW-1:0]; mem_wdata = val_q;
            oh_d = WHERE_W'(pos_q); os_d = STAT_OK;
          end
          OP_REV: begin
            i_d = '0; j_d = ne - 1'b1;
          end
          OP_SORT: i_d = '0;
          OP_FIND: begin
            i_d = '0; k_d = '0; pend_d = 1'b0;
          end
          OP_CLEAR: begin
            n_d = '0; os_d = STAT_OK;
          end
          OP_RANGE: begin
            i_d = pos_q; j_d = pos_q + cnt_q;
          end
          default: os_d = STAT_ERR;
        endcase
      end
      S_RDOUT: begin
        ow_d = from_word(rdata); oh_d = WHERE_W'(i_q); os_d = STAT_OK;
        if (op_q == OP_REMOVE) n_d = n_q - 1'b1;
      end
      S_SHUP: begin
        if (c_shup) begin
          mem_raddr = AW'(i_q - 1'b1);
        end else begin
          mem_we = 1'b1; mem_waddr = pos_q[AW-1:0]; mem_wdata = val_q;
          n_d = n_q + 1'b1; oh_d = WHERE_W'(pos_q); os_d = STAT_OK;
        end
      end
      S_SHUP_WR: begin
        mem_we = 1'b1; i_d = i_q - 1'b1;
      end
      S_ERCHK: i_d = pos_q;
      S_ERSH: begin
        if (c_ersh) begin
          mem_raddr = AW'(i_q + 1'b1);
        end else begin
          n_d = n_q - 1'b1; oh_d = WHERE_W'(pos_q); os_d = STAT_OK;
        end
      end
      S_ERSH_WR: begin
        mem_we = 1'b1; i_d = i_q + 1'b1;
      end
      S_REV_A: if (!c_rev) os_d = STAT_OK;
      S_REV_B: begin
        ta_d = rdata; mem_raddr = j_q[AW-1:0];
      end
      S_REV_C: mem_we = 1'b1;
      S_REV_D: begin
        mem_we = 1'b1; mem_waddr = j_q[AW-1:0]; mem_wdata = ta_q;
        i_d = i_q + 1'b1; j_d = j_q - 1'b1;
      end
      S_SO_I: begin
        j_d = i_q + 1'b1;
        if (!c_iltn) os_d = STAT_OK;
      end
      S_SO_LD: ta_d = rdata;
      S_SO_J: begin
        mem_raddr = j_q[AW-1:0];
        if (!c_jltn) begin
          mem_we = 1'b1; mem_wdata = ta_q; i_d = i_q + 1'b1;
        end
      end
      S_SO_CMP: begin
        if (c_gt) begin
          mem_we = 1'b1; mem_waddr = j_q[AW-1:0]; mem_wdata = ta_q; ta_d = rdata;
        end
        j_d = j_q + 1'b1;
      end
      S_FI: begin
        if (!c_fi) begin
          ret_d = S_IDLE; ol_d = 1'b1;
          if (pend_q) begin
            ow_d = from_word(pw_q); oh_d = WHERE_W'(ph_q); os_d = STAT_OK;
          end else begin
            ow_d = '0; oh_d = '0; os_d = STAT_NONE;
          end
        end
      end
      S_FI_CMP: begin
        i_d = i_q + 1'b1;
        if (c_eq) begin
          if (pend_q) begin
            ow_d = from_word(pw_q); oh_d = WHERE_W'(ph_q); os_d = STAT_OK;
            ol_d = 1'b0; ret_d = S_FI;
          end
          pend_d = 1'b1; pw_d = rdata; ph_d = i_q; k_d = k_q + 1'b1;
        end
      end
      S_RG_OUT: begin
        ow_d = from_word(rdata); oh_d = WHERE_W'(i_q); os_d = STAT_OK;
        ol_d = c_rlast; ret_d = c_rlast ? S_IDLE : S_RG;
        i_d = i_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      n_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; pos_q <= pos_d; cnt_q <= cnt_d; val_q <= val_d;
    i_q <= i_d; j_q <= j_d; k_q <= k_d; ta_q <= ta_d; pw_q <= pw_d; ph_q <= ph_d;
    ow_q <= ow_d; oh_q <= oh_d; os_q <= os_d; ol_q <= ol_d;
  end

  assign in_i.ready           = state_q == S_IDLE;
  assign out_o.valid          = state_q == S_OUT;
  assign out_o.word           = ow_q;
  assign out_o.where          = oh_q;
  assign out_o.status         = os_q;
  assign out_o.current_length = LEN_W'(n_q);
  assign out_o.last           = ol_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(CAPACITY)) else $error("length above capacity");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("request taken while result pending");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_OUT) |-> !mem_we) else $error("store write while idle");
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_acc |=> state_q == S_DISP) else $error("accepted request not dispatched");
endmodule
`default_nettype wire

// ===== hdl/bale_mem.sv =====
// Word store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bale_mem #(
  parameter int DEPTH = bale_pkg::CAPACITY_DEF,
  parameter int WIDTH = bale_pkg::WORD_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== tb/tb_bounded_array_list_engine_core.sv =====
// Self-checking testbench of the bounded array list engine core.
`timescale 1ns / 1ps
module tb_bounded_array_list_engine_core;
  import bale_pkg::*;

  localparam int CAP = 64;
  localparam int WD_LIMIT = 200000;

  typedef struct packed {
    logic signed [DATA_W-1:0] word;
    logic [WHERE_W-1:0]       where;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         current_length;
    logic                     last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  bale_in_if  req_if ();
  bale_out_if res_if ();

  bounded_array_list_engine_core #(.CAPACITY(CAP), .WORD_BITS(32)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (res_if.source)
  );

  logic signed [31:0] list_mirror [CAP];
  int unsigned        list_len;
  result_t            pending_results [$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 hold_off_cycles;
  int                 idle_cycles;
  bit                 failed;
  bit                 run_done;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic result_t make_result(logic signed [31:0] w, int unsigned at,
                                          logic [STAT_W-1:0] st, bit lst);
    result_t r;
    r.word           = w;
    r.where          = at[WHERE_W-1:0];
    r.status         = st;
    r.current_length = list_len[LEN_W-1:0];
    r.last           = lst;
    return r;
  endfunction

  function automatic void queue_result(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_list_op(logic [3:0] opc, int unsigned pos,
                                          int unsigned cnt, logic signed [31:0] val);
    int unsigned n;
    int          hits;
    logic signed [31:0] t;
    n = list_len;
    hits = 0;
    case (opc)
      OP_APPEND: begin
        if (n < CAP) begin
          list_mirror[n] = val;
          list_len = n + 1;
          queue_result(make_result(0, n, STAT_OK, 1));
          return;
        end
      end
      OP_REMOVE: begin
        if (n > 0) begin
          list_len = n - 1;
          queue_result(make_result(list_mirror[n-1], n - 1, STAT_OK, 1));
          return;
        end
      end
      OP_INSERT: begin
        if (n < CAP && pos <= n) begin
          for (int i = n; i > pos; i--) list_mirror[i] = list_mirror[i-1];
          list_mirror[pos] = val;
          list_len = n + 1;
          queue_result(make_result(0, pos, STAT_OK, 1));
          return;
        end
      end
      OP_ERASE: begin
        if (pos < n && list_mirror[pos] == val) begin
          for (int i = pos; i + 1 < n; i++) list_mirror[i] = list_mirror[i+1];
          list_len = n - 1;
          queue_result(make_result(0, pos, STAT_OK, 1));
          return;
        end
      end
      OP_READ: begin
        if (pos < n) begin
          queue_result(make_result(list_mirror[pos], pos, STAT_OK, 1));
          return;
        end
      end
      OP_WRITE: begin
        if (pos < n) begin
          list_mirror[pos] = val;
          queue_result(make_result(0, pos, STAT_OK, 1));
          return;
        end
      end
      OP_REV: begin
        for (int i = 0; i < n / 2; i++) begin
          t = list_mirror[i];
          list_mirror[i] = list_mirror[n-1-i];
          list_mirror[n-1-i] = t;
        end
        queue_result(make_result(0, 0, STAT_OK, 1));
        return;
      end
      OP_SORT: begin
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++)
            if (list_mirror[i] > list_mirror[j]) begin
              t = list_mirror[i];
              list_mirror[i] = list_mirror[j];
              list_mirror[j] = t;
            end
        queue_result(make_result(0, 0, STAT_OK, 1));
        return;
      end
      OP_FIND: begin
        for (int i = 0; i < n && hits < MAX_RUN; i++)
          if (list_mirror[i] == val) begin
            queue_result(make_result(val, i, STAT_OK, 0));
            hits++;
          end
        if (hits == 0) queue_result(make_result(0, 0, STAT_NONE, 1));
        else pending_results[$].last = 1'b1;
        return;
      end
      OP_CLEAR: begin
        list_len = 0;
        queue_result(make_result(0, 0, STAT_OK, 1));
        return;
      end
      OP_RANGE: begin
        if (cnt != 0 && cnt <= MAX_RUN && pos + cnt <= n) begin
          for (int i = 0; i < cnt; i++)
            queue_result(make_result(list_mirror[pos+i], pos + i, STAT_OK,
                                     i + 1 == cnt));
          return;
        end
      end
      default: ;
    endcase
    queue_result(make_result(0, 0, STAT_ERR, 1));
  endfunction

  task automatic send_request(logic [3:0] opc, int unsigned pos, int unsigned cnt,
                              logic signed [31:0] val);
    int unsigned pos_sent;
    int unsigned cnt_sent;
    pos_sent = pos[POS_W-1:0];
    cnt_sent = cnt[CNT_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= opc;
    req_if.position    <= pos[POS_W-1:0];
    req_if.range_count <= cnt[CNT_W-1:0];
    req_if.operand     <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_list_op(opc, pos_sent, cnt_sent, val);
  endtask

  task automatic drain;
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Bias positions to the valid span, with some beyond it.
  function automatic int unsigned pick_pos();
    if ($urandom_range(9) == 0 || list_len == 0) return $urandom_range(127);
    return $urandom_range(list_len);
  endfunction

  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return list_len != 0 ? list_mirror[$urandom_range(list_len - 1)] : 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res_if.ready    <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        failed = 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        if (res_if.word !== exp_r.word) begin
          $error("word exp %0d got %0d", exp_r.word, res_if.word);
          failed = 1'b1;
        end
        if (res_if.where !== exp_r.where) begin
          $error("where exp %0d got %0d", exp_r.where, res_if.where);
          failed = 1'b1;
        end
        if (res_if.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, res_if.status);
          failed = 1'b1;
        end
        if (res_if.current_length !== exp_r.current_length) begin
          $error("current_length exp %0d got %0d", exp_r.current_length,
                 res_if.current_length);
          failed = 1'b1;
        end
        if (res_if.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, res_if.last);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || run_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_bounded_array_list_engine_core: FAIL");
      $finish;
    end
  end

  task automatic test_boundaries;
    send_request(OP_REMOVE, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0);
    send_request(OP_FIND, 0, 0, 0);
    send_request(OP_RANGE, 0, 1, 0);
    send_request(OP_INSERT, 1, 0, 5);
    send_request(OP_INSERT, 0, 0, 32'sh7fffffff);
    send_request(OP_APPEND, 0, 0, 32'sh80000000);
    send_request(OP_APPEND, 0, 0, -1);
    send_request(OP_INSERT, 3, 0, 0);
    send_request(OP_WRITE, 3, 0, 9);
    send_request(OP_ERASE, 1, 0, 0);
    send_request(OP_ERASE, 3, 0, 0);
    send_request(OP_WRITE, 0, 0, -1);
    send_request(OP_FIND, 0, 0, -1);
    send_request(OP_REV, 0, 0, 0);
    send_request(OP_SORT, 0, 0, 0);
    send_request(OP_RANGE, 0, 0, 0);
    send_request(OP_RANGE, 1, 3, 0);
    send_request(OP_RANGE, 0, 3, 0);
    send_request(4'd11, 127, 127, 0);
    send_request(4'd15, 0, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0);
    drain();
  endtask

  task automatic test_full_list;
    for (int i = 0; i < CAP; i++) send_request(OP_APPEND, 0, 0, $urandom_range(3));
    send_request(OP_APPEND, 0, 0, 1);
    send_request(OP_INSERT, 0, 0, 1);
    send_request(OP_FIND, 0, 0, 0);
    send_request(OP_RANGE, 0, 64, 0);
    send_request(OP_RANGE, 0, 65, 0);
    send_request(OP_REMOVE, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_ops(int unsigned n_items);
    logic [3:0] opc;
    int unsigned pos;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(19) == 0) opc = 4'($urandom_range(15, 11));
      else if ($urandom_range(3) == 0) opc = OP_APPEND;
      else opc = 4'($urandom_range(10));
      if (opc == OP_CLEAR && $urandom_range(2) != 0) opc = OP_APPEND;
      if (opc == OP_SORT && list_len > 24) opc = OP_READ;
      pos = pick_pos();
      send_request(opc, pos, $urandom_range(1, 8) + ($urandom_range(15) == 0 ? 120 : 0),
                   pick_val());
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_off_cycles = 300;
    for (int k = 0; k < 12; k++) send_request(OP_RANGE, 0, list_len > 4 ? 4 : list_len,
                                              0);
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    failed = 1'b0;
    run_done = 1'b0;
    idle_cycles = 0;
    hold_off_cycles = 0;
    list_len = 0;
    send_idle_pct = 28;
    recv_idle_pct = 60;
    req_if.valid = 1'b0;
    req_if.operation = OP_APPEND;
    req_if.position = '0;
    req_if.range_count = '0;
    req_if.operand = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundaries();
    test_full_list();
    test_backpressure();
    test_random_ops(20);
    send_idle_pct = 60;
    recv_idle_pct = 28;
    test_random_ops(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(20);
    run_done = 1'b1;
    if (!failed && pending_results.size() == 0)
      $display("tb_bounded_array_list_engine_core: PASS");
    else
      $display("tb_bounded_array_list_engine_core: FAIL");
    $finish;
  end

endmodule
